@@ src/trimmed_mean_adc_voltage_top_macros.svh @@
`ifndef TRIMMED_MEAN_ADC_VOLTAGE_TOP_MACROS_SVH
`define TRIMMED_MEAN_ADC_VOLTAGE_TOP_MACROS_SVH

// check an implication on every clock edge outside reset
`define TMAV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check an implication with its consequent in the next cycle, outside reset
`define TMAV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/trmadc_pkg.sv @@
package trmadc_pkg;

  localparam int ADC_W          = 12;
  localparam int MV_W           = 13;
  localparam int PROD_W         = ADC_W + MV_W;
  localparam int BATCH_SIZE_DEF = 5;

  localparam logic [ADC_W-1:0] ADC_FULL_SCALE = 12'd4095;
  localparam logic [MV_W-1:0]  VREF_RESET     = 13'd3280;

  typedef logic [ADC_W-1:0] adc_t;
  typedef logic [MV_W-1:0]  mv_t;
  typedef logic [PROD_W-1:0] prod_t;

  // floor(x / 4095) for x < 4095 * 8192: x = hi*4095 + (hi + lo)
  function automatic mv_t div_full_scale(input prod_t x);
    logic [MV_W-1:0]  hi;
    logic [ADC_W-1:0] lo;
    logic [MV_W:0]    rem;
    logic [MV_W-1:0]  q;
    hi  = x[PROD_W-1:ADC_W];
    lo  = x[ADC_W-1:0];
    rem = {1'b0, hi} + {2'b00, lo};
    q   = hi;
    if (rem >= {1'b0, ADC_FULL_SCALE, 1'b0}) begin
      q = hi + 13'd2;
    end else if (rem >= {2'b00, ADC_FULL_SCALE}) begin
      q = hi + 13'd1;
    end
    return q;
  endfunction

endpackage

@@ src/trimmed_mean_adc_voltage_top.sv @@
// A completed batch passes through registers a, b, c and out; stalls can hold it.
// Throughput: one sample request per cycle while in_stall is low; one result per
// BATCH_SIZE samples. in_stall rises only when the result pipeline is full and
// out_stall holds it. Reset (synchronous, rst_n low): batch cleared, pipeline
// emptied, vref_mv back to 3280.
module trimmed_mean_adc_voltage_top #(
  parameter int BATCH_SIZE = trmadc_pkg::BATCH_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [trmadc_pkg::MV_W-1:0]  cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [trmadc_pkg::ADC_W-1:0] in_adc_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [trmadc_pkg::ADC_W-1:0] out_mean_code,
  output logic [trmadc_pkg::MV_W-1:0]  out_voltage_mv
);
  import trmadc_pkg::*;

  `include "trimmed_mean_adc_voltage_top_macros.svh"

  localparam int CNT_W  = $clog2(BATCH_SIZE);
  localparam int SUM_W  = ADC_W + $clog2(BATCH_SIZE);
  localparam int DIV    = BATCH_SIZE - 2;
  localparam int RK     = SUM_W + $clog2(DIV);
  localparam int RM_W   = SUM_W + 1;
  localparam longint unsigned RM = ((64'd1 << RK) + DIV - 1) / DIV;
  localparam int RP_W   = SUM_W + RM_W;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BATCH_SIZE - 1);
  localparam logic [RM_W-1:0]  RECIP    = RM_W'(RM);

  logic [MV_W-1:0]  vref_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  adc_t             min_r, min_nxt, max_r, max_nxt;
  logic [SUM_W-1:0] tsum_nxt;

  logic             a_vld_r, b_vld_r, c_vld_r, out_vld_r;
  logic [SUM_W-1:0] a_tsum_r;
  adc_t             b_mean_r, c_mean_r, out_mean_r;
  prod_t            c_prod_r;
  mv_t              out_mv_r;
  logic [RP_W-1:0]  recip_prod;

  logic ready_out, ready_c, ready_b, ready_a;
  logic in_acc, last;

  function automatic logic [RP_W-1:0] b_mean_dummy_free(input logic [SUM_W-1:0] t);
    return RP_W'(t) * RP_W'(RECIP);
  endfunction

  assign ready_out = !out_vld_r || !out_stall;
  assign ready_c   = !c_vld_r || ready_out;
  assign ready_b   = !b_vld_r || ready_c;
  assign ready_a   = !a_vld_r || ready_b;

  assign in_stall  = !ready_a;
  assign in_acc    = in_valid && ready_a;
  assign last      = (cnt_r == CNT_LAST);

  always_comb begin
    sum_nxt  = sum_r + SUM_W'(in_adc_sample);
    min_nxt  = (in_adc_sample < min_r) ? in_adc_sample : min_r;
    max_nxt  = (in_adc_sample > max_r) ? in_adc_sample : max_r;
    tsum_nxt = sum_nxt - SUM_W'(min_nxt) - SUM_W'(max_nxt);
  end

  assign recip_prod = RP_W'(b_mean_dummy_free(a_tsum_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r <= VREF_RESET;
    end else if (cfg_wr_en) begin
      vref_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= ADC_FULL_SCALE;
      max_r <= '0;
    end else if (in_acc) begin
      if (last) begin
        cnt_r <= '0;
        sum_r <= '0;
        min_r <= ADC_FULL_SCALE;
        max_r <= '0;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        sum_r <= sum_nxt;
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (ready_a) begin
        a_vld_r <= in_acc && last;
      end
      if (ready_b) begin
        b_vld_r <= a_vld_r;
      end
      if (ready_c) begin
        c_vld_r <= b_vld_r;
      end
      if (ready_out) begin
        out_vld_r <= c_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last) begin
      a_tsum_r <= tsum_nxt;
    end
    if (ready_b && a_vld_r) begin
      b_mean_r <= recip_prod[RK +: ADC_W];
    end
    if (ready_c && b_vld_r) begin
      c_mean_r <= b_mean_r;
      c_prod_r <= PROD_W'(b_mean_r) * PROD_W'(vref_r);
    end
    if (ready_out && c_vld_r) begin
      out_mean_r <= c_mean_r;
      out_mv_r   <= div_full_scale(c_prod_r);
    end
  end

  assign out_valid      = out_vld_r;
  assign out_mean_code  = out_mean_r;
  assign out_voltage_mv = out_mv_r;

  `TMAV_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNT_LAST, "batch count out of range")
  `TMAV_ASSERT_IMP(a_min_max, cnt_r != '0, min_r <= max_r, "batch min above max")
  `TMAV_ASSERT_NEXT(a_last_launch, in_acc && last, a_vld_r && cnt_r == '0,
                    "completed batch not launched")
  `TMAV_ASSERT_NEXT(a_cnt_step, in_acc && !last, cnt_r == $past(cnt_r) + CNT_W'(1),
                    "batch count did not advance")

endmodule

@@ verif/tb.sv @@
module tb;
  import trmadc_pkg::*;

  localparam int BATCH        = BATCH_SIZE_DEF;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    adc_t mean;
    mv_t  mv;
  } batch_result_t;

  class trimmed_mean_tracker;
    mv_t           vref;
    int unsigned   n_in_batch;
    bit [31:0]     batch_sum;
    adc_t          batch_lo;
    adc_t          batch_hi;
    batch_result_t due_q[$];
    int unsigned   fail_count;

    function new();
      vref       = VREF_RESET;
      fail_count = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      n_in_batch = 0;
      batch_sum  = '0;
      batch_lo   = ADC_FULL_SCALE;
      batch_hi   = '0;
    endfunction

    function void take_sample(adc_t s);
      batch_result_t r;
      bit [31:0]     trimmed;
      batch_sum += s;
      if (s < batch_lo) batch_lo = s;
      if (s > batch_hi) batch_hi = s;
      n_in_batch++;
      if (n_in_batch == BATCH) begin
        trimmed = (batch_sum - batch_lo - batch_hi) / (BATCH - 2);
        r.mean  = adc_t'(trimmed);
        r.mv    = mv_t'((trimmed * vref) / ADC_FULL_SCALE);
        due_q.push_back(r);
        clear_batch();
      end
    endfunction

    function void check_mean(adc_t mean, mv_t mv);
      batch_result_t exp_r;
      if (due_q.size() == 0) begin
        $display({"%0t: result with no batch pending: expected none, ",
                  "got mean_code %0d voltage_mv %0d"}, $time, mean, mv);
        fail_count++;
        return;
      end
      exp_r = due_q.pop_front();
      if (mean !== exp_r.mean) begin
        $display("%0t: mean_code expected %0d got %0d", $time, exp_r.mean, mean);
        fail_count++;
      end
      if (mv !== exp_r.mv) begin
        $display("%0t: voltage_mv expected %0d got %0d", $time, exp_r.mv, mv);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  mv_t  cfg_wr_data;
  logic in_valid;
  logic in_stall;
  adc_t in_adc_sample;
  logic out_valid;
  logic out_stall;
  adc_t out_mean_code;
  mv_t  out_voltage_mv;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  trimmed_mean_tracker tracker = new();

  trimmed_mean_adc_voltage_top #(
    .BATCH_SIZE(BATCH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mean_code (out_mean_code),
    .out_voltage_mv(out_voltage_mv)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall = (rst_n === 1'b1) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_mean(out_mean_code, out_voltage_mv);
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic push_sample(input adc_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_adc_sample = s;
    do @(posedge clk); while (in_stall);
    tracker.take_sample(s);
    @(negedge clk);
  endtask

  task automatic write_vref(input mv_t v);
    in_valid = 1'b0;
    while (tracker.due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en     = 1'b0;
    tracker.vref  = v;
  endtask

  function automatic adc_t pick_sample(adc_t centre);
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ADC_FULL_SCALE;
      2, 3: begin
        v = int'(centre) + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return adc_t'(v);
      end
      default: return adc_t'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic run_random(input int n);
    adc_t centre;
    centre = '0;
    for (int i = 0; i < n; i++) begin
      if (i % BATCH == 0) centre = adc_t'($urandom_range(0, 4095));
      push_sample(pick_sample(centre));
    end
  endtask

  adc_t directed_set[25] = '{
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
    12'd0,    12'd4095, 12'd100,  12'd200,  12'd300,
    12'd4095, 12'd4095, 12'd0,    12'd0,    12'd7,
    12'd1,    12'd2,    12'd3,    12'd2730, 12'd1365
  };

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_adc_sample = '0;
    out_stall     = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 50;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_set[i]) push_sample(directed_set[i]);

    write_vref(13'd5000);
    run_random(110);

    send_idle_pct = 50;
    recv_idle_pct = 24;
    write_vref(13'd0);
    run_random(90);
    write_vref(13'd8191);
    run_random(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_vref(13'd1);
    run_random(90);
    write_vref(mv_t'($urandom_range(0, 8191)));
    run_random(90);
    write_vref(13'd4095);
    run_random(90);

    // drain outstanding results
    in_valid = 1'b0;
    while (tracker.due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.fail_count == 0) begin
      $display("trimmed_mean_adc_voltage_top test passed");
    end else begin
      $display("trimmed_mean_adc_voltage_top test failed");
    end
    $finish;
  end

  initial begin
    #1200000;
    $display("trimmed_mean_adc_voltage_top test failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/trmadc_pkg.sv
src/trimmed_mean_adc_voltage_top.sv
verif/tb.sv
